### rtl/pts_pkg.sv
// Shared constants and types for the PWM timing solver.
// No dependencies; pts_fit, pts_skid, the top level and the checker refer to it by scoped names.
`default_nettype none

package pts_pkg;

	// PWM timer clock base in Hz.
	localparam logic [22:0] CLK_HZ = 23'd8000000;

	// Duty scale in milli-percent and the rounding offset for it.
	localparam logic [16:0] MPCT_FULL = 17'd100000;
	localparam logic [15:0] MPCT_HALF = 16'd50000;

	// Largest 10-bit compare code.
	localparam logic [9:0] CODE_MAX = 10'd1023;

	// Scale factors for milli units and for percent.
	localparam logic [9:0] MILLI = 10'd1000;
	localparam logic [6:0] PCT = 7'd100;

	// Prescaler selection and the period division set up for it.
	typedef struct packed {
		logic        found;
		logic [2:0]  k;
		logic [31:0] num;
		logic [30:0] den;
		logic [16:0] duty_a;
		logic [16:0] duty_b;
	} fit_t;

	// One finished result transaction.
	typedef struct packed {
		logic        in_range;
		logic [8:0]  period_count;
		logic [2:0]  prescale_log2;
		logic [9:0]  duty_a_code;
		logic [9:0]  duty_b_code;
		logic [31:0] actual_freq_mhz;
		logic [16:0] actual_duty_a_mpct;
		logic [16:0] actual_duty_b_mpct;
	} result_t;

endpackage

`default_nettype wire

### rtl/pts_fit.sv
// Prescaler search stage: tries all eight prescalers at once and picks the first fit.
// Depends on pts_pkg for the clock constant and the fit_t type.
`default_nettype none

module pts_fit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire logic [23:0]      freq_hz,
	input  wire logic [16:0]      duty_a_mpct,
	input  wire logic [16:0]      duty_b_mpct,
	output logic                  out_valid,
	output pts_pkg::fit_t         fit
);

	pts_pkg::fit_t fit_c;
	logic          valid_s2;
	pts_pkg::fit_t fit_s2;

	// A prescaler fits when the rounded count lies in 2..256. Both bounds are
	// checked as compares against multiples of the scaled frequency.
	always_comb begin
		logic [40:0] dn;
		logic [40:0] lhs;
		logic [7:0]  ok;
		logic [30:0] den_sel;
		ok = '0;
		for (int i = 0; i < 8; i++) begin
			dn = 41'(freq_hz) << i;
			lhs = 41'(pts_pkg::CLK_HZ) + (dn >> 1);
			ok[i] = (lhs >= (dn << 1)) && (lhs < ((dn << 8) + dn));
		end
		fit_c.found = |ok;
		fit_c.k = '0;
		for (int i = 7; i >= 0; i--) begin
			if (ok[i]) begin
				fit_c.k = 3'(i);
			end
		end
		den_sel = 31'(41'(freq_hz) << fit_c.k);
		if (fit_c.found) begin
			fit_c.den = den_sel;
			fit_c.num = 32'(pts_pkg::CLK_HZ) + 32'(den_sel >> 1);
		end else begin
			fit_c.den = 31'd1;
			fit_c.num = '0;
		end
		fit_c.duty_a = (duty_a_mpct > pts_pkg::MPCT_FULL) ? pts_pkg::MPCT_FULL : duty_a_mpct;
		fit_c.duty_b = (duty_b_mpct > pts_pkg::MPCT_FULL) ? pts_pkg::MPCT_FULL : duty_b_mpct;
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fit_s2 <= fit_c;
		end
	end

	assign out_valid = valid_s2;
	assign fit = fit_s2;

endmodule

`default_nettype wire

### rtl/pts_div.sv
// Pipelined restoring divider with a sideband that travels with each transaction.
// Standalone; used several times by the top level.
`default_nettype none

module pts_div #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 16,
	parameter int Q_W    = 16,
	parameter int STAGES = 4,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [Q_W-1:0]         quo,
	output logic [DEN_W-1:0]       rem,
	output logic [SIDE_W-1:0]      side_out
);

	// Quotient bits resolved per stage, and the padded quotient width.
	localparam int SPS = (Q_W + STAGES - 1) / STAGES;
	localparam int QP  = SPS * STAGES;
	localparam int EXW = NUM_W + QP;

	// The quotient must fit in QP bits, so the bits above QP start the remainder.
	logic [EXW-1:0] num_x;
	assign num_x = EXW'(num);

	logic              valid_s [STAGES];
	logic [DEN_W-1:0]  rem_s   [STAGES];
	logic [QP-1:0]     nq_s    [STAGES];
	logic [DEN_W-1:0]  den_s   [STAGES];
	logic [SIDE_W-1:0] side_s  [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic              v_i;
		logic [DEN_W-1:0]  r_i;
		logic [QP-1:0]     nq_i;
		logic [DEN_W-1:0]  d_i;
		logic [SIDE_W-1:0] sd_i;
		logic [DEN_W-1:0]  r_o;
		logic [QP-1:0]     nq_o;

		if (g == 0) begin : g_first
			assign v_i  = in_valid;
			assign r_i  = DEN_W'(num_x >> QP);
			assign nq_i = num_x[QP-1:0];
			assign d_i  = den;
			assign sd_i = side_in;
		end else begin : g_next
			assign v_i  = valid_s[g-1];
			assign r_i  = rem_s[g-1];
			assign nq_i = nq_s[g-1];
			assign d_i  = den_s[g-1];
			assign sd_i = side_s[g-1];
		end

		// For each quotient bit of the stage, shift one numerator bit into the remainder and subtract where it fits.
		always_comb begin
			logic [DEN_W:0] t;
			r_o = r_i;
			nq_o = nq_i;
			for (int j = 0; j < SPS; j++) begin
				t = {r_o, nq_o[QP-1]};
				nq_o = {nq_o[QP-2:0], 1'b0};
				if (t >= {1'b0, d_i}) begin
					r_o = DEN_W'(t - {1'b0, d_i});
					nq_o[0] = 1'b1;
				end else begin
					r_o = t[DEN_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (adv) begin
				valid_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g]  <= r_o;
				nq_s[g]   <= nq_o;
				den_s[g]  <= d_i;
				side_s[g] <= sd_i;
			end
		end
	end

	assign out_valid = valid_s[STAGES-1];
	assign quo       = nq_s[STAGES-1][Q_W-1:0];
	assign rem       = rem_s[STAGES-1];
	assign side_out  = side_s[STAGES-1];

endmodule

`default_nettype wire

### rtl/pts_skid.sv
// Output register with a spare entry, so the pipeline keeps moving while a result waits.
// Depends on pts_pkg for the result_t type.
`default_nettype none

module pts_skid (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pipe_valid,
	input  wire pts_pkg::result_t pipe_data,
	output logic                  adv,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pts_pkg::result_t      out_data
);

	logic             ov_q;
	logic             sv_q;
	pts_pkg::result_t od_q;
	pts_pkg::result_t sd_q;
	logic             take;
	logic             inc;

	// The pipeline advances whenever the spare entry is free.
	assign adv  = !sv_q;
	assign take = ov_q && out_ready;
	assign inc  = adv && pipe_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (take) begin
				sv_q <= 1'b0;
			end
		end else if (!ov_q || take) begin
			ov_q <= inc;
		end else if (inc) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (take) begin
				od_q <= sd_q;
			end
		end else if (!ov_q || take) begin
			if (inc) begin
				od_q <= pipe_data;
			end
		end else if (inc) begin
			sd_q <= pipe_data;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

endmodule

`default_nettype wire

### rtl/pwm_timing_solver_top.sv
// PWM timing solver, top level: prescaler search, four divider phases and the output buffer.
// Depends on pts_pkg, pts_fit, pts_div and pts_skid.
`default_nettype none

// The block takes one request transaction per clock while the spare entry
// of its output buffer is free, and returns one result transaction for each,
// in order. Each result passes through a chain of pipelined restoring
// dividers: the period count (3 stages), the achieved frequency quotient and
// the two duty codes (6 stages), the frequency fraction and duty whole parts
// (3 stages), and the duty fractions (3 stages), with one register between
// phases for the multiplications. A frequency of zero or one that no
// prescaler can reach returns in_range low and every other field zero.

module pwm_timing_solver_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [23:0] freq_hz,
	input  wire logic [16:0] duty_a_mpct,
	input  wire logic [16:0] duty_b_mpct,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic             in_range,
	output logic [8:0]       period_count,
	output logic [2:0]       prescale_log2,
	output logic [9:0]       duty_a_code,
	output logic [9:0]       duty_b_code,
	output logic [31:0]      actual_freq_mhz,
	output logic [16:0]      actual_duty_a_mpct,
	output logic [16:0]      actual_duty_b_mpct
);

	logic adv;

	// Input stage.
	logic        v_s1;
	logic [23:0] freq_s1;
	logic [16:0] da_s1;
	logic [16:0] db_s1;

	assign req_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			freq_s1 <= freq_hz;
			da_s1   <= duty_a_mpct;
			db_s1   <= duty_b_mpct;
		end
	end

	// Prescaler search.
	logic          v_s2;
	pts_pkg::fit_t fit_s2;

	pts_fit u_fit (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (v_s1),
		.freq_hz    (freq_s1),
		.duty_a_mpct(da_s1),
		.duty_b_mpct(db_s1),
		.out_valid  (v_s2),
		.fit        (fit_s2)
	);

	// Period count: rounded clock over scaled frequency.
	logic        va_o;
	logic [8:0]  n_a;
	logic [37:0] side_a;

	pts_div #(.NUM_W(32), .DEN_W(31), .Q_W(9), .STAGES(3), .SIDE_W(38)) u_div_n (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s2),
		.num     (fit_s2.num),
		.den     (fit_s2.den),
		.side_in ({fit_s2.found, fit_s2.k, fit_s2.duty_a, fit_s2.duty_b}),
		.out_valid(va_o),
		.quo     (n_a),
		.rem     (),
		.side_out(side_a)
	);

	// Duty code numerators and the clock scaled by the prescaler.
	logic        v_s3;
	logic        found_s3;
	logic [2:0]  k_s3;
	logic [8:0]  n_s3;
	logic [26:0] na_s3;
	logic [26:0] nb_s3;
	logic [22:0] clkd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= va_o;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_s3 <= side_a[37];
			k_s3     <= side_a[36:34];
			n_s3     <= n_a;
			na_s3    <= 27'(side_a[33:17]) * 27'({n_a, 2'b00}) + 27'(pts_pkg::MPCT_HALF);
			nb_s3    <= 27'(side_a[16:0]) * 27'({n_a, 2'b00}) + 27'(pts_pkg::MPCT_HALF);
			clkd_s3  <= pts_pkg::CLK_HZ >> side_a[36:34];
		end
	end

	// Achieved frequency quotient and both duty codes.
	logic        vf_o;
	logic        vca_o;
	logic        vcb_o;
	logic [22:0] q2_b;
	logic [8:0]  r2_b;
	logic [8:0]  n_b;
	logic [10:0] ca_raw;
	logic [10:0] cb_raw;
	logic [2:0]  k_b;
	logic        found_b;

	pts_div #(.NUM_W(23), .DEN_W(9), .Q_W(23), .STAGES(6), .SIDE_W(9)) u_div_f (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s3),
		.num     (clkd_s3),
		.den     (n_s3),
		.side_in (n_s3),
		.out_valid(vf_o),
		.quo     (q2_b),
		.rem     (r2_b),
		.side_out(n_b)
	);

	pts_div #(.NUM_W(27), .DEN_W(17), .Q_W(11), .STAGES(6), .SIDE_W(3)) u_div_ca (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s3),
		.num     (na_s3),
		.den     (pts_pkg::MPCT_FULL),
		.side_in (k_s3),
		.out_valid(vca_o),
		.quo     (ca_raw),
		.rem     (),
		.side_out(k_b)
	);

	pts_div #(.NUM_W(27), .DEN_W(17), .Q_W(11), .STAGES(6), .SIDE_W(1)) u_div_cb (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s3),
		.num     (nb_s3),
		.den     (pts_pkg::MPCT_FULL),
		.side_in (found_s3),
		.out_valid(vcb_o),
		.quo     (cb_raw),
		.rem     (),
		.side_out(found_b)
	);

	// Clamp the codes and set up the fraction and duty divisions.
	logic        v_s4;
	logic        found_s4;
	logic [2:0]  k_s4;
	logic [8:0]  n_s4;
	logic [22:0] q2_s4;
	logic [17:0] fnum_s4;
	logic [9:0]  ca_s4;
	logic [9:0]  cb_s4;
	logic [16:0] dna_s4;
	logic [16:0] dnb_s4;
	logic [9:0]  ca_c;
	logic [9:0]  cb_c;

	assign ca_c = (ca_raw > 11'(pts_pkg::CODE_MAX)) ? pts_pkg::CODE_MAX : ca_raw[9:0];
	assign cb_c = (cb_raw > 11'(pts_pkg::CODE_MAX)) ? pts_pkg::CODE_MAX : cb_raw[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= vf_o && vca_o && vcb_o;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_s4 <= found_b;
			k_s4     <= k_b;
			n_s4     <= n_b;
			q2_s4    <= q2_b;
			fnum_s4  <= 18'(r2_b) * 18'(pts_pkg::MILLI);
			ca_s4    <= ca_c;
			cb_s4    <= cb_c;
			dna_s4   <= 17'(ca_c) * 17'(pts_pkg::PCT);
			dnb_s4   <= 17'(cb_c) * 17'(pts_pkg::PCT);
		end
	end

	// Frequency fraction and the whole part of each achieved duty.
	logic        vff_o;
	logic        vwa_o;
	logic        vwb_o;
	logic [9:0]  ff_c;
	logic [35:0] side_c;
	logic [6:0]  wa_c;
	logic [10:0] ra_c;
	logic [9:0]  ca_c2;
	logic [6:0]  wb_c;
	logic [10:0] rb_c;
	logic [9:0]  cb_c2;

	pts_div #(.NUM_W(18), .DEN_W(9), .Q_W(10), .STAGES(3), .SIDE_W(36)) u_div_ff (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s4),
		.num     (fnum_s4),
		.den     (n_s4),
		.side_in ({found_s4, k_s4, n_s4, q2_s4}),
		.out_valid(vff_o),
		.quo     (ff_c),
		.rem     (),
		.side_out(side_c)
	);

	pts_div #(.NUM_W(17), .DEN_W(11), .Q_W(7), .STAGES(3), .SIDE_W(10)) u_div_wa (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s4),
		.num     (dna_s4),
		.den     ({n_s4, 2'b00}),
		.side_in (ca_s4),
		.out_valid(vwa_o),
		.quo     (wa_c),
		.rem     (ra_c),
		.side_out(ca_c2)
	);

	pts_div #(.NUM_W(17), .DEN_W(11), .Q_W(7), .STAGES(3), .SIDE_W(10)) u_div_wb (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s4),
		.num     (dnb_s4),
		.den     ({n_s4, 2'b00}),
		.side_in (cb_s4),
		.out_valid(vwb_o),
		.quo     (wb_c),
		.rem     (rb_c),
		.side_out(cb_c2)
	);

	// Scale the duty remainders for their fractions.
	logic        v_s5;
	logic [35:0] side_s5;
	logic [9:0]  ff_s5;
	logic [9:0]  ca_s5;
	logic [9:0]  cb_s5;
	logic [6:0]  wa_s5;
	logic [6:0]  wb_s5;
	logic [19:0] fa_s5;
	logic [19:0] fb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= vff_o && vwa_o && vwb_o;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_c;
			ff_s5   <= ff_c;
			ca_s5   <= ca_c2;
			cb_s5   <= cb_c2;
			wa_s5   <= wa_c;
			wb_s5   <= wb_c;
			fa_s5   <= 20'(ra_c) * 20'(pts_pkg::MILLI);
			fb_s5   <= 20'(rb_c) * 20'(pts_pkg::MILLI);
		end
	end

	// Fractions of the two achieved duties.
	logic        vfa_o;
	logic        vfb_o;
	logic [9:0]  fra_d;
	logic [9:0]  frb_d;
	logic [62:0] side_da;
	logic [16:0] side_db;
	logic [8:0]  n_s5;

	assign n_s5 = side_s5[31:23];

	pts_div #(.NUM_W(20), .DEN_W(11), .Q_W(10), .STAGES(3), .SIDE_W(63)) u_div_fa (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s5),
		.num     (fa_s5),
		.den     ({n_s5, 2'b00}),
		.side_in ({side_s5, ff_s5, ca_s5, wa_s5}),
		.out_valid(vfa_o),
		.quo     (fra_d),
		.rem     (),
		.side_out(side_da)
	);

	pts_div #(.NUM_W(20), .DEN_W(11), .Q_W(10), .STAGES(3), .SIDE_W(17)) u_div_fb (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v_s5),
		.num     (fb_s5),
		.den     ({n_s5, 2'b00}),
		.side_in ({cb_s5, wb_s5}),
		.out_valid(vfb_o),
		.quo     (frb_d),
		.rem     (),
		.side_out(side_db)
	);

	// Final assembly; a request with no fit reports all zeros.
	logic             found_d;
	logic [2:0]       k_d;
	logic [8:0]       n_d;
	logic [22:0]      q2_d;
	logic [9:0]       ff_d;
	logic [9:0]       ca_d;
	logic [6:0]       wa_d;
	logic [9:0]       cb_d;
	logic [6:0]       wb_d;
	logic             v_s6;
	pts_pkg::result_t res_c;
	pts_pkg::result_t res_s6;

	assign found_d = side_da[62];
	assign k_d     = side_da[61:59];
	assign n_d     = side_da[58:50];
	assign q2_d    = side_da[49:27];
	assign ff_d    = side_da[26:17];
	assign ca_d    = side_da[16:7];
	assign wa_d    = side_da[6:0];
	assign cb_d    = side_db[16:7];
	assign wb_d    = side_db[6:0];

	always_comb begin
		res_c = '0;
		if (found_d) begin
			res_c.in_range           = 1'b1;
			res_c.period_count       = n_d;
			res_c.prescale_log2      = k_d;
			res_c.duty_a_code        = ca_d;
			res_c.duty_b_code        = cb_d;
			res_c.actual_freq_mhz    = 32'(q2_d) * 32'(pts_pkg::MILLI) + 32'(ff_d);
			res_c.actual_duty_a_mpct = 17'(wa_d) * 17'(pts_pkg::MILLI) + 17'(fra_d);
			res_c.actual_duty_b_mpct = 17'(wb_d) * 17'(pts_pkg::MILLI) + 17'(frb_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= vfa_o && vfb_o;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6 <= res_c;
		end
	end

	// Output buffer.
	pts_pkg::result_t res_out;

	pts_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.pipe_valid(v_s6),
		.pipe_data (res_s6),
		.adv       (adv),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_data  (res_out)
	);

	assign in_range           = res_out.in_range;
	assign period_count       = res_out.period_count;
	assign prescale_log2      = res_out.prescale_log2;
	assign duty_a_code        = res_out.duty_a_code;
	assign duty_b_code        = res_out.duty_b_code;
	assign actual_freq_mhz    = res_out.actual_freq_mhz;
	assign actual_duty_a_mpct = res_out.actual_duty_a_mpct;
	assign actual_duty_b_mpct = res_out.actual_duty_b_mpct;

endmodule

`default_nettype wire

### dv/pwm_timing_solver_checker.sv
// Checker for the PWM timing solver: watches both channels, predicts each result and compares.
// Depends on pts_pkg for the result structure; used by pwm_timing_solver_top_test.
`timescale 1ns / 100ps

module pwm_timing_solver_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_ready,
	input  wire logic [23:0] freq_hz,
	input  wire logic [16:0] duty_a_mpct,
	input  wire logic [16:0] duty_b_mpct,
	input  wire logic        res_valid,
	input  wire logic        res_ready,
	input  wire logic        in_range,
	input  wire logic [8:0]  period_count,
	input  wire logic [2:0]  prescale_log2,
	input  wire logic [9:0]  duty_a_code,
	input  wire logic [9:0]  duty_b_code,
	input  wire logic [31:0] actual_freq_mhz,
	input  wire logic [16:0] actual_duty_a_mpct,
	input  wire logic [16:0] actual_duty_b_mpct,
	output int               errors,
	output int               pending
);

	pts_pkg::result_t solutions_due[$];

	// Rounded compare code for one duty over a full scale of 4N.
	function automatic logic [9:0] compare_code(input logic [16:0] mpct, input int unsigned full);
		longint unsigned c;
		longint unsigned m;
		m = (mpct > 17'd100000) ? 100000 : mpct;
		c = (m * full + 50000) / 100000;
		if (c > 1023) c = 1023;
		return c[9:0];
	endfunction

	// Achieved duty in milli-percent recovered from a compare code.
	function automatic logic [16:0] achieved_duty(input logic [9:0] code, input int unsigned full);
		longint unsigned num;
		longint unsigned v;
		num = code * 100;
		v = (num / full) * 1000 + ((num % full) * 1000) / full;
		return v[16:0];
	endfunction

	// Prescaler search and all derived outputs for one request.
	function automatic pts_pkg::result_t solve_timing(input logic [23:0] f,
			input logic [16:0] da, input logic [16:0] db);
		pts_pkg::result_t r;
		longint unsigned den;
		longint unsigned cand;
		longint unsigned d;
		longint unsigned af;
		int unsigned full;
		r = '0;
		if (f == 0) return r;
		for (int i = 0; i < 8; i++) begin
			den = longint'(f) << i;
			cand = (64'd8000000 + den / 2) / den;
			if (cand >= 2 && cand <= 256) begin
				r.in_range = 1'b1;
				r.period_count = cand[8:0];
				r.prescale_log2 = i[2:0];
				break;
			end
		end
		if (!r.in_range) return r;
		full = 4 * r.period_count;
		r.duty_a_code = compare_code(da, full);
		r.duty_b_code = compare_code(db, full);
		d = longint'(r.period_count) << r.prescale_log2;
		af = (64'd8000000 / d) * 1000 + ((64'd8000000 % d) * 1000) / d;
		r.actual_freq_mhz = af[31:0];
		r.actual_duty_a_mpct = achieved_duty(r.duty_a_code, full);
		r.actual_duty_b_mpct = achieved_duty(r.duty_b_code, full);
		return r;
	endfunction

	// Predict on each accepted request and compare each accepted result.
	always @(posedge clk or negedge arst_n) begin
		pts_pkg::result_t got;
		pts_pkg::result_t want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (req_valid && req_ready)
				solutions_due.push_back(solve_timing(freq_hz, duty_a_mpct, duty_b_mpct));
			if (res_valid && res_ready) begin
				got = '{in_range, period_count, prescale_log2, duty_a_code, duty_b_code,
					actual_freq_mhz, actual_duty_a_mpct, actual_duty_b_mpct};
				if (solutions_due.size() == 0) begin
					$display("%0t: unexpected result transaction %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = solutions_due.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
			pending <= solutions_due.size();
		end
	end
endmodule

### dv/pwm_timing_solver_top_test.sv
// Testbench top for the PWM timing solver: clock, reset, request stimulus and verdict.
// Depends on pwm_timing_solver_top, pwm_timing_solver_checker and pts_pkg.
`timescale 1ns / 100ps

module pwm_timing_solver_top_test;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [23:0] freq_hz = '0;
	logic [16:0] duty_a_mpct = '0;
	logic [16:0] duty_b_mpct = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        in_range;
	logic [8:0]  period_count;
	logic [2:0]  prescale_log2;
	logic [9:0]  duty_a_code;
	logic [9:0]  duty_b_code;
	logic [31:0] actual_freq_mhz;
	logic [16:0] actual_duty_a_mpct;
	logic [16:0] actual_duty_b_mpct;
	int          errors;
	int          pending;
	int          send_idle_pct = 20;
	int          recv_idle_pct = 46;
	int          hold_off = 0;
	int          cycles = 0;

	always #4 clk = ~clk;

	pwm_timing_solver_top uut (.*);
	pwm_timing_solver_checker checker_i (.*);

	// Overall cycle limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side readiness, with random stalls and an optional long hold-off.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one request transaction and wait until it is accepted.
	task automatic send_request(input logic [23:0] f, input logic [16:0] da, input logic [16:0] db);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		freq_hz <= f;
		duty_a_mpct <= da;
		duty_b_mpct <= db;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Random frequency: mostly the solvable band, sometimes any value.
	function automatic logic [23:0] pick_freq();
		case ($urandom_range(9))
			0: return $urandom();
			1: return $urandom_range(300);
			2: return $urandom_range(2200000, 5000000);
			default: return $urandom_range(150, 2000000);
		endcase
	endfunction

	function automatic logic [16:0] pick_duty();
		case ($urandom_range(7))
			0: return $urandom();
			1: return $urandom_range(99990, 100010);
			default: return $urandom_range(100000);
		endcase
	endfunction

	initial begin
		logic [23:0] freqs[] = '{0, 1, 122, 123, 15624, 15625, 31250, 4000000, 2666666,
			2666667, 16777215, 100, 1000, 20000, 50000, 62500, 5333333, 3200000};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests across frequency edges and duty extremes.
		foreach (freqs[i])
			send_request(freqs[i], (i % 3 == 0) ? 17'h1FFFF : 17'd0,
				(i % 2 == 0) ? 17'd100000 : 17'd50000);
		send_request(31250, 17'd99950, 17'd99951);
		send_request(31250, 17'd1, 17'd65535);

		// Long receiver hold-off while requests keep coming.
		hold_off <= 300;
		repeat (80) send_request(pick_freq(), pick_duty(), pick_duty());

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 46 : 0;
			recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 20 : 0;
			repeat (600) send_request(pick_freq(), pick_duty(), pick_duty());
		end
		req_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

### sim.f
rtl/pts_pkg.sv
rtl/pts_fit.sv
rtl/pts_div.sv
rtl/pts_skid.sv
rtl/pwm_timing_solver_top.sv
dv/pwm_timing_solver_checker.sv
dv/pwm_timing_solver_top_test.sv
